// ===== rtl/utf8d_pkg.sv =====
// Shared types, widths and tables for the UTF-8 byte stream decoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
package utf8d_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 3;
    localparam int CP_W        = 32;
    localparam int QUEUE_DEPTH = 4;

    // Bits that one continuation byte contributes.
    localparam int CONT_SHIFT = 6;

    localparam logic [LEN_W-1:0] LEN_1 = 3'd1;
    localparam logic [LEN_W-1:0] LEN_2 = 3'd2;
    localparam logic [LEN_W-1:0] LEN_3 = 3'd3;
    localparam logic [LEN_W-1:0] LEN_4 = 3'd4;
    localparam logic [LEN_W-1:0] LEN_5 = 3'd5;
    localparam logic [LEN_W-1:0] LEN_6 = 3'd6;

    // One classified byte travelling from the front to the back.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              first;  // opens a sequence
        logic              last;   // closes a sequence
        logic [LEN_W-1:0]  len;    // sequence length, valid with first
    } t_tok;

    // Sequence length from the lead byte.
    function automatic logic [LEN_W-1:0] lead_length(input logic [BYTE_W-1:0] b);
        logic [LEN_W-1:0] len;
        if (b < 8'hC0) begin
            len = LEN_1;
        end else if (b < 8'hE0) begin
            len = LEN_2;
        end else if (b < 8'hF0) begin
            len = LEN_3;
        end else if (b < 8'hF8) begin
            len = LEN_4;
        end else if (b < 8'hFC) begin
            len = LEN_5;
        end else begin
            len = LEN_6;
        end
        return len;
    endfunction

    // Marker bits to strip from the accumulated value for each length.
    function automatic logic [CP_W-1:0] len_offset(input logic [LEN_W-1:0] len);
        logic [CP_W-1:0] off;
        case (len)
            LEN_2:   off = 32'h0000_3080;
            LEN_3:   off = 32'h000E_2080;
            LEN_4:   off = 32'h03C8_2080;
            LEN_5:   off = 32'hFA08_2080;
            LEN_6:   off = 32'h8208_2080;
            default: off = '0;
        endcase
        return off;
    endfunction

endpackage

// ===== rtl/utf8d_front.sv =====
// Front end: accepts raw bytes, tracks the open sequence and tags each byte.
// Depends on utf8d_pkg; pushes tokens into utf8d_queue.
module utf8d_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [utf8d_pkg::BYTE_W-1:0]    i_byte_in,
    output logic                            o_stall,
    input  logic                            i_full,
    output logic                            o_push,
    output utf8d_pkg::t_tok                 o_tok
);

    logic [utf8d_pkg::LEN_W-1:0] r_bytes_left;
    logic [utf8d_pkg::LEN_W-1:0] n_bytes_left;
    logic [utf8d_pkg::LEN_W-1:0] lead_len;
    logic                        opening;

    assign o_stall  = i_full;
    assign o_push   = i_valid && !i_full;
    assign opening  = (r_bytes_left == '0);
    assign lead_len = utf8d_pkg::lead_length(i_byte_in);

    always_comb begin
        if (opening) begin
            n_bytes_left = lead_len - utf8d_pkg::LEN_W'(1);
        end else begin
            n_bytes_left = r_bytes_left - utf8d_pkg::LEN_W'(1);
        end
    end

    always_comb begin
        o_tok.data  = i_byte_in;
        o_tok.first = opening;
        o_tok.last  = (n_bytes_left == '0);
        o_tok.len   = lead_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= '0;
        end else if (o_push) begin
            r_bytes_left <= n_bytes_left;
        end
    end

endmodule

// ===== rtl/utf8d_queue.sv =====
// Short token queue between front and back; circular buffer with a fill count.
// Depends on utf8d_pkg for the token type.
module utf8d_queue #(
    parameter int DEPTH = utf8d_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  utf8d_pkg::t_tok  i_tok,
    input  logic             i_pop,
    output utf8d_pkg::t_tok  o_tok,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    utf8d_pkg::t_tok  r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_tok   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/utf8d_back.sv =====
// Back end: folds tagged bytes into the accumulator and registers each result.
// Depends on utf8d_pkg; pops tokens from utf8d_queue.
module utf8d_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  utf8d_pkg::t_tok               i_tok,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [utf8d_pkg::CP_W-1:0]    o_code_point,
    output logic [utf8d_pkg::LEN_W-1:0]   o_seq_length
);

    logic [utf8d_pkg::CP_W-1:0]  r_acc;
    logic [utf8d_pkg::LEN_W-1:0] r_len;
    logic [utf8d_pkg::CP_W-1:0]  n_acc;
    logic [utf8d_pkg::LEN_W-1:0] n_len;
    logic                        r_out_valid;
    logic [utf8d_pkg::CP_W-1:0]  r_out_cp;
    logic [utf8d_pkg::LEN_W-1:0] r_out_len;
    logic                        out_free;

    assign out_free = !r_out_valid || !i_stall;
    // A non-final byte never touches the output register, so it may always advance.
    assign o_pop    = !i_empty && (!i_tok.last || out_free);

    always_comb begin
        if (i_tok.first) begin
            n_acc = utf8d_pkg::CP_W'(i_tok.data);
            n_len = i_tok.len;
        end else begin
            n_acc = {r_acc[utf8d_pkg::CP_W-utf8d_pkg::CONT_SHIFT-1:0],
                     utf8d_pkg::CONT_SHIFT'(0)} + utf8d_pkg::CP_W'(i_tok.data);
            n_len = r_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_acc <= n_acc;
            r_len <= n_len;
        end
        if (o_pop && i_tok.last) begin
            r_out_cp  <= n_acc - utf8d_pkg::len_offset(n_len);
            r_out_len <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_tok.last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_code_point = r_out_cp;
    assign o_seq_length = r_out_len;

endmodule

// ===== rtl/utf8_byte_stream_decoder.sv =====
// Top level of the UTF-8 byte stream decoder: front, token queue and back.
// Depends on utf8d_pkg, utf8d_front, utf8d_queue and utf8d_back.
//
// Usage:
//   Input channel: i_valid / i_byte_in, with o_stall driven back. A byte is
//   taken at a rising edge with i_valid high and o_stall low. Bytes 00-BF
//   open and close a one-byte sequence; C0-FF open a 2 to 6 byte sequence
//   and the following bytes are consumed as continuations, unchecked.
//   Output channel: o_valid / o_code_point / o_seq_length, with i_stall from
//   the receiver. One transaction leaves for each completed sequence.
//   Path: the last byte of a sequence is written into the queue as a token,
//   popped by the back end once the output register is free, and its
//   result is then registered and shown on the outputs.
//   Throughput: one byte per cycle while the queue is not full; the back end
//   consumes one queued token per cycle unless a final token meets a stall.
//   Receiver stall: the result holds in the output register; the back end
//   keeps absorbing non-final bytes, and the queue (QUEUE_DEPTH tokens)
//   fills before o_stall rises.
//   Reset (i_rst_n low at an edge): the queue empties, no sequence is open
//   and o_valid drops; o_stall is low from the first cycle after reset.
module utf8_byte_stream_decoder #(
    parameter int QUEUE_DEPTH = utf8d_pkg::QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [utf8d_pkg::BYTE_W-1:0]  i_byte_in,
    output logic                          o_stall,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [utf8d_pkg::CP_W-1:0]    o_code_point,
    output logic [utf8d_pkg::LEN_W-1:0]   o_seq_length
);

    utf8d_pkg::t_tok push_tok;
    utf8d_pkg::t_tok pop_tok;
    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_empty;

    // Classify each accepted byte and track how many bytes the sequence still owes.
    utf8d_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_byte_in (i_byte_in),
        .o_stall   (o_stall),
        .i_full    (q_full),
        .o_push    (push),
        .o_tok     (push_tok)
    );

    // Decouple the two halves so a receiver stall reaches the input only when full.
    utf8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_tok   (push_tok),
        .i_pop   (pop),
        .o_tok   (pop_tok),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Accumulate, strip the length markers and hold the result for the receiver.
    utf8d_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (q_empty),
        .i_tok        (pop_tok),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_code_point (o_code_point),
        .o_seq_length (o_seq_length)
    );

endmodule
